>>> src/rsbp_pkg.sv
package rsbp_pkg;

   localparam int PIX_W     = 8;
   localparam int GAIN_W    = 10;
   localparam int GAIN_FRAC = 8;
   localparam int SECT_W    = 3;
   localparam int HUE_W     = 11;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

   localparam logic [SECT_W-1:0] SECT_RED_YELLOW   = 3'd0;
   localparam logic [SECT_W-1:0] SECT_YELLOW_GREEN = 3'd1;
   localparam logic [SECT_W-1:0] SECT_GREEN_CYAN   = 3'd2;
   localparam logic [SECT_W-1:0] SECT_CYAN_BLUE    = 3'd3;
   localparam logic [SECT_W-1:0] SECT_BLUE_MAGENTA = 3'd4;
   localparam logic [SECT_W-1:0] SECT_MAGENTA_RED  = 3'd5;

endpackage

>>> src/rgb_saturation_boost_pixel.sv
// Saturation boost of an 8-bit RGB pixel stream through the HSV hexcone.
// Input beats arrive on req_* (valid/stall), one pixel per beat; results
// leave on rsp_* (valid/stall), one pixel per input beat, in order.
// csr_wr_en/csr_wr_data load the saturation gain (Q2.8, 256 = 1.0); write
// it only while no pixel is in flight.
// The pipeline is a front stage, then FRACTION_BITS+1 stages of bit-serial
// divide, then FRACTION_BITS+1 stages of bit-serial square root, then gain,
// hexcone and output stages.
// Throughput: one pixel per clock while rsp_stall is low.
// When rsp_stall is high with a result waiting, the whole pipeline holds
// and req_stall is raised in the same cycle; nothing is dropped or
// repeated.
// Reset clears all valid bits and sets the gain to 1.0.
module rgb_saturation_boost_pixel #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rsbp_pkg::PIX_W-1:0]    req_red_in,
   input  logic [rsbp_pkg::PIX_W-1:0]    req_green_in,
   input  logic [rsbp_pkg::PIX_W-1:0]    req_blue_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rsbp_pkg::PIX_W-1:0]    rsp_red_out,
   output logic [rsbp_pkg::PIX_W-1:0]    rsp_green_out,
   output logic [rsbp_pkg::PIX_W-1:0]    rsp_blue_out,
   input  logic                          csr_wr_en,
   input  logic [rsbp_pkg::GAIN_W-1:0]   csr_wr_data
);
   import rsbp_pkg::*;

   localparam int F      = FRACTION_BITS;
   localparam int QW     = F + 1;
   localparam int DSIDE  = 1 + SECT_W + PIX_W;
   localparam int SSIDE  = DSIDE + F;
   localparam logic [QW-1:0] ONE = QW'(1) << F;

   logic en;
   logic [GAIN_W-1:0] gain_ff;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   // front: max, min, hue sector and remainder
   logic [PIX_W-1:0] mx, mn, delta;
   logic signed [11:0] r12, g12, b12, d12, h12;
   logic [HUE_W-1:0] hu, dd, m2, m3, m4, m5, msel;
   logic [SECT_W-1:0] sector;
   logic [PIX_W-1:0] hrem;

   always_comb begin
      mx = req_red_in;
      if (req_green_in > mx) mx = req_green_in;
      if (req_blue_in > mx) mx = req_blue_in;
      mn = req_red_in;
      if (req_green_in < mn) mn = req_green_in;
      if (req_blue_in < mn) mn = req_blue_in;
      delta = mx - mn;
   end

   always_comb begin
      r12 = signed'({4'b0, req_red_in});
      g12 = signed'({4'b0, req_green_in});
      b12 = signed'({4'b0, req_blue_in});
      d12 = signed'({4'b0, delta});
      priority if (mx == req_red_in) begin
         h12 = g12 - b12;
      end else if (mx == req_green_in) begin
         h12 = (d12 <<< 1) + b12 - r12;
      end else begin
         h12 = (d12 <<< 2) + r12 - g12;
      end
      if (h12 < 0) h12 = h12 + (d12 <<< 2) + (d12 <<< 1);
      hu = h12[HUE_W-1:0];
   end

   always_comb begin
      dd = HUE_W'(delta);
      m2 = dd << 1;
      m3 = m2 + dd;
      m4 = dd << 2;
      m5 = m4 + dd;
      priority if (hu >= m5) begin
         sector = SECT_MAGENTA_RED;   msel = m5;
      end else if (hu >= m4) begin
         sector = SECT_BLUE_MAGENTA;  msel = m4;
      end else if (hu >= m3) begin
         sector = SECT_CYAN_BLUE;     msel = m3;
      end else if (hu >= m2) begin
         sector = SECT_GREEN_CYAN;    msel = m2;
      end else if (hu >= dd) begin
         sector = SECT_YELLOW_GREEN;  msel = dd;
      end else begin
         sector = SECT_RED_YELLOW;    msel = '0;
      end
      hrem = PIX_W'(hu - msel);
   end

   logic             a_valid_ff;
   logic [PIX_W-1:0] a_max_ff, a_delta_ff, a_rem_ff;
   logic [DSIDE-1:0] a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_max_ff   <= mx;
         a_delta_ff <= delta;
         a_rem_ff   <= hrem;
         a_side_ff  <= {delta == '0, sector, mx};
      end
   end

   logic             d_valid;
   logic [QW-1:0]    d_sat;
   logic [F-1:0]     d_frac;
   logic [DSIDE-1:0] d_side;

   rsbp_div_pipe #(.FRAC_W(F), .SIDE_W(DSIDE)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .in_max    (a_max_ff),
      .in_delta  (a_delta_ff),
      .in_rem    (a_rem_ff),
      .in_side   (a_side_ff),
      .out_valid (d_valid),
      .out_sat   (d_sat),
      .out_frac  (d_frac),
      .out_side  (d_side)
   );

   logic             s_valid;
   logic [QW-1:0]    s_root;
   logic [SSIDE-1:0] s_side;

   rsbp_sqrt_pipe #(.FRAC_W(F), .SIDE_W(SSIDE)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_sat    (d_sat),
      .in_side   ({d_side, d_frac}),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // gain stage
   logic [GAIN_W+QW-1:0] gprod, gshift;
   logic [QW-1:0]        boost_in;

   assign gprod    = (GAIN_W+QW)'(gain_ff) * (GAIN_W+QW)'(s_root);
   assign gshift   = gprod >> GAIN_FRAC;
   assign boost_in = (gshift > (GAIN_W+QW)'(ONE)) ? ONE : QW'(gshift);

   logic             b_valid_ff;
   logic [QW-1:0]    b_boost_ff;
   logic [SSIDE-1:0] b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_boost_ff <= boost_in;
         b_side_ff  <= s_side;
      end
   end

   // hexcone factors
   logic [F-1:0]      b_frac;
   logic [PIX_W-1:0]  b_max;
   logic [SECT_W-1:0] b_sector;
   logic              b_grey;
   logic [QW-1:0]     one_minus_f;
   logic [QW+F-1:0]   bf;
   logic [2*QW-1:0]   bt;
   logic [QW-1:0]     p_in, q_in, t_in;

   assign {b_grey, b_sector, b_max, b_frac} = b_side_ff;
   assign one_minus_f = ONE - QW'(b_frac);
   assign bf   = (QW+F)'(b_boost_ff) * (QW+F)'(b_frac);
   assign bt   = (2*QW)'(b_boost_ff) * (2*QW)'(one_minus_f);
   assign p_in = ONE - b_boost_ff;
   assign q_in = ONE - QW'(bf >> F);
   assign t_in = ONE - QW'(bt >> F);

   logic              c_valid_ff, c_plain_ff;
   logic [QW-1:0]     c_p_ff, c_q_ff, c_t_ff;
   logic [PIX_W-1:0]  c_max_ff;
   logic [SECT_W-1:0] c_sector_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_plain_ff  <= b_grey || (b_boost_ff == '0);
         c_p_ff      <= p_in;
         c_q_ff      <= q_in;
         c_t_ff      <= t_in;
         c_max_ff    <= b_max;
         c_sector_ff <= b_sector;
      end
   end

   // rebuild channels
   logic [QW-1:0]       mr, mg, mb;
   logic [PIX_W+QW-1:0] pr, pg, pb;

   always_comb begin
      unique case (c_sector_ff)
         SECT_RED_YELLOW:   begin mr = ONE;    mg = c_t_ff; mb = c_p_ff; end
         SECT_YELLOW_GREEN: begin mr = c_q_ff; mg = ONE;    mb = c_p_ff; end
         SECT_GREEN_CYAN:   begin mr = c_p_ff; mg = ONE;    mb = c_t_ff; end
         SECT_CYAN_BLUE:    begin mr = c_p_ff; mg = c_q_ff; mb = ONE;    end
         SECT_BLUE_MAGENTA: begin mr = c_t_ff; mg = c_p_ff; mb = ONE;    end
         default:           begin mr = ONE;    mg = c_p_ff; mb = c_q_ff; end
      endcase
      if (c_plain_ff) begin
         mr = ONE;
         mg = ONE;
         mb = ONE;
      end
   end

   assign pr = (PIX_W+QW)'(c_max_ff) * (PIX_W+QW)'(mr);
   assign pg = (PIX_W+QW)'(c_max_ff) * (PIX_W+QW)'(mg);
   assign pb = (PIX_W+QW)'(c_max_ff) * (PIX_W+QW)'(mb);

   logic             o_valid_ff;
   logic [PIX_W-1:0] o_red_ff, o_green_ff, o_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_red_ff   <= pr[F +: PIX_W];
         o_green_ff <= pg[F +: PIX_W];
         o_blue_ff  <= pb[F +: PIX_W];
      end
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_red_out   = o_red_ff;
   assign rsp_green_out = o_green_ff;
   assign rsp_blue_out  = o_blue_ff;

endmodule

>>> src/rsbp_div_pipe.sv
module rsbp_div_pipe #(
   parameter int FRAC_W = 16,
   parameter int SIDE_W = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [rsbp_pkg::PIX_W-1:0]  in_max,
   input  logic [rsbp_pkg::PIX_W-1:0]  in_delta,
   input  logic [rsbp_pkg::PIX_W-1:0]  in_rem,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [FRAC_W:0]             out_sat,
   output logic [FRAC_W-1:0]           out_frac,
   output logic [SIDE_W-1:0]           out_side
);
   import rsbp_pkg::*;

   localparam int N = FRAC_W + 1;

   // sat = (delta << F) / max, frac = (rem << F) / delta; one quotient bit per stage
   logic             valid_ff [N];
   logic [PIX_W-1:0] max_ff   [N];
   logic [PIX_W-1:0] delta_ff [N];
   logic [PIX_W-1:0] srem_ff  [N];
   logic [PIX_W-1:0] frem_ff  [N];
   logic [FRAC_W:0]  sq_ff    [N];
   logic [FRAC_W:0]  fq_ff    [N];
   logic [SIDE_W-1:0] side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic              v_prev;
      logic [PIX_W-1:0]  max_prev, delta_prev, srem_prev, frem_prev;
      logic [FRAC_W:0]   sq_prev, fq_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [PIX_W:0]    s_sh, f_sh;
      logic              s_ge, f_ge;
      logic [PIX_W-1:0]  srem_in, frem_in;
      logic [FRAC_W:0]   sq_in, fq_in;

      if (k == 0) begin : g_first
         assign v_prev     = in_valid;
         assign max_prev   = in_max;
         assign delta_prev = in_delta;
         assign srem_prev  = in_delta;
         assign frem_prev  = in_rem;
         assign sq_prev    = '0;
         assign fq_prev    = '0;
         assign side_prev  = in_side;
         assign s_sh       = {1'b0, srem_prev};
         assign f_sh       = {1'b0, frem_prev};
      end else begin : g_next
         assign v_prev     = valid_ff[k-1];
         assign max_prev   = max_ff[k-1];
         assign delta_prev = delta_ff[k-1];
         assign srem_prev  = srem_ff[k-1];
         assign frem_prev  = frem_ff[k-1];
         assign sq_prev    = sq_ff[k-1];
         assign fq_prev    = fq_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign s_sh       = {srem_prev, 1'b0};
         assign f_sh       = {frem_prev, 1'b0};
      end

      assign s_ge    = s_sh >= {1'b0, max_prev};
      assign f_ge    = f_sh >= {1'b0, delta_prev};
      assign srem_in = s_ge ? PIX_W'(s_sh - {1'b0, max_prev}) : PIX_W'(s_sh);
      assign frem_in = f_ge ? PIX_W'(f_sh - {1'b0, delta_prev}) : PIX_W'(f_sh);
      assign sq_in   = {sq_prev[FRAC_W-1:0], s_ge};
      assign fq_in   = {fq_prev[FRAC_W-1:0], f_ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            max_ff[k]   <= max_prev;
            delta_ff[k] <= delta_prev;
            srem_ff[k]  <= srem_in;
            frem_ff[k]  <= frem_in;
            sq_ff[k]    <= sq_in;
            fq_ff[k]    <= fq_in;
            side_ff[k]  <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_sat   = sq_ff[N-1];
   assign out_frac  = fq_ff[N-1][FRAC_W-1:0];
   assign out_side  = side_ff[N-1];

endmodule

>>> src/rsbp_sqrt_pipe.sv
module rsbp_sqrt_pipe #(
   parameter int FRAC_W = 16,
   parameter int SIDE_W = 28
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [FRAC_W:0]   in_sat,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [FRAC_W:0]   out_root,
   output logic [SIDE_W-1:0] out_side
);
   import rsbp_pkg::*;

   localparam int N = FRAC_W + 1;

   // root = floor(sqrt(sat << F)), one root bit per stage
   logic              valid_ff [N];
   logic [FRAC_W+2:0] rem_ff   [N];
   logic [FRAC_W:0]   root_ff  [N];
   logic [FRAC_W:0]   sat_ff   [N];
   logic [SIDE_W-1:0] side_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic              v_prev;
      logic [FRAC_W+2:0] rem_prev;
      logic [FRAC_W:0]   root_prev, sat_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [2*N-1:0]    radicand;
      logic [1:0]        pair;
      logic [FRAC_W+2:0] rem_sh, trial, rem_in;
      logic              ge;
      logic [FRAC_W:0]   root_in;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign sat_prev  = in_sat;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign sat_prev  = sat_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign radicand = {1'b0, sat_prev, {FRAC_W{1'b0}}};
      assign pair     = radicand[2*N-1-2*k -: 2];
      assign rem_sh   = {rem_prev[FRAC_W:0], pair};
      assign trial    = {1'b0, root_prev[FRAC_W-1:0], 2'b01};
      assign ge       = rem_sh >= trial;
      assign rem_in   = ge ? rem_sh - trial : rem_sh;
      assign root_in  = {root_prev[FRAC_W-1:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            sat_ff[k]  <= sat_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

>>> bench/tb_rgb_saturation_boost_pixel.sv
module tb_rgb_saturation_boost_pixel;
   timeunit 1ns;
   timeprecision 1ps;
   import rsbp_pkg::*;

   localparam int FB = 16;
   localparam logic [63:0] ONE = 64'd1 << FB;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_t;

   class boost_scoreboard;
      pixel_t            pending[$];
      logic [GAIN_W-1:0] gain;
      int                errors;
      int                checked;

      function new();
         gain = GAIN_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] x);
         logic [63:0] r;
         r = 0;
         for (int k = 31; k >= 0; k--) begin
            if ((r | (64'd1 << k)) * (r | (64'd1 << k)) <= x) r = r | (64'd1 << k);
         end
         return r;
      endfunction

      function pixel_t boost_pixel(pixel_t px);
         logic [63:0] r, g, b, mx, mn, dl, s, rt, bst, hu, sec, f, p, q, t, mr, mg, mb;
         pixel_t o;
         r = px.red; g = px.green; b = px.blue;
         mx = r; mn = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         dl = mx - mn;
         mr = ONE; mg = ONE; mb = ONE;
         if (mx != 0 && dl != 0) begin
            s = (dl << FB) / mx;
            rt = int_sqrt(s << FB);
            bst = (gain * rt) >> GAIN_FRAC;
            if (bst > ONE) bst = ONE;
            if (bst != 0) begin
               if (mx == r) hu = 6 * dl + g - b;
               else if (mx == g) hu = 2 * dl + b - r;
               else hu = 4 * dl + r - g;
               if (hu >= 6 * dl) hu = hu - 6 * dl;
               sec = hu / dl;
               f = ((hu % dl) << FB) / dl;
               p = ONE - bst;
               q = ONE - ((bst * f) >> FB);
               t = ONE - ((bst * (ONE - f)) >> FB);
               case (sec[SECT_W-1:0])
                  SECT_RED_YELLOW:   begin mr = ONE; mg = t;   mb = p;   end
                  SECT_YELLOW_GREEN: begin mr = q;   mg = ONE; mb = p;   end
                  SECT_GREEN_CYAN:   begin mr = p;   mg = ONE; mb = t;   end
                  SECT_CYAN_BLUE:    begin mr = p;   mg = q;   mb = ONE; end
                  SECT_BLUE_MAGENTA: begin mr = t;   mg = p;   mb = ONE; end
                  default:           begin mr = ONE; mg = p;   mb = q;   end
               endcase
            end
         end
         o.red = PIX_W'((mx * mr) >> FB);
         o.green = PIX_W'((mx * mg) >> FB);
         o.blue = PIX_W'((mx * mb) >> FB);
         return o;
      endfunction

      function void note_pixel(pixel_t px);
         pending.push_back(boost_pixel(px));
      endfunction

      function void check_pixel(pixel_t got);
         pixel_t exp_px;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat %h", $realtime, got);
            errors++;
            return;
         end
         exp_px = pending.pop_front();
         checked++;
         if (got.red !== exp_px.red) begin
            $display("%0t: red expected %0d actual %0d", $realtime, exp_px.red, got.red);
            errors++;
         end
         if (got.green !== exp_px.green) begin
            $display("%0t: green expected %0d actual %0d", $realtime, exp_px.green,
                     got.green);
            errors++;
         end
         if (got.blue !== exp_px.blue) begin
            $display("%0t: blue expected %0d actual %0d", $realtime, exp_px.blue, got.blue);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_wr_en;
   logic [PIX_W-1:0] req_red_in, req_green_in, req_blue_in;
   logic [PIX_W-1:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic [GAIN_W-1:0] csr_wr_data;

   boost_scoreboard sb = new();
   int idle_cycles;
   int long_hold;
   int sent;

   rgb_saturation_boost_pixel u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_red_in(req_red_in), .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      reset = 1'b1; req_valid = 1'b0; rsp_stall = 1'b0; csr_wr_en = 1'b0;
      req_red_in = '0; req_green_in = '0; req_blue_in = '0; csr_wr_data = '0;
      long_hold = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_pixel({req_red_in, req_green_in,
                                                             req_blue_in});
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel({rsp_red_out, rsp_green_out,
                                                              rsp_blue_out});
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("rgb_saturation_boost_pixel: mismatch");
         $finish;
      end
   end

   // receiver: random stall per beat, plus one long hold
   initial begin
      int w;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
         end
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if ($urandom_range(0, 2) == 0) w = 0;
         rsp_stall <= (w != 0);
         if (w != 0) begin
            repeat (w) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock iff rsp_valid);
      end
   end

   task automatic send_pixel(input pixel_t px, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= px.red;
      req_green_in <= px.green;
      req_blue_in <= px.blue;
      @(posedge clock iff !req_stall);
      sent++;
   endtask

   task automatic drain_and_set_gain(input logic [GAIN_W-1:0] g);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.gain = g;
   endtask

   function automatic pixel_t rand_pixel();
      pixel_t px;
      int m;
      px.red = PIX_W'($urandom);
      px.green = PIX_W'($urandom);
      px.blue = PIX_W'($urandom);
      m = $urandom_range(0, 9);
      if (m == 0) px.green = px.red;
      if (m == 1) px.blue = px.red;
      if (m == 2) begin px.green = px.red; px.blue = px.red; end
      if (m == 3) px.blue = px.green;
      return px;
   endfunction

   initial begin
      pixel_t dir_px[$];
      logic [GAIN_W-1:0] gains[$];
      int gap;
      sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      dir_px = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
                 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
                 24'h01FF00, 24'h00FF01, 24'h0100FF, 24'h0001FF, 24'hFFFE00, 24'h010000,
                 24'hC864FA, 24'h7F3F1F, 24'hAA55AA};
      foreach (dir_px[i]) send_pixel(dir_px[i], 0);
      gains = '{10'd0, 10'd1023, 10'd128, 10'd384, 10'd256, 10'd1, 10'd512};
      foreach (gains[k]) begin
         drain_and_set_gain(gains[k]);
         foreach (dir_px[i]) send_pixel(dir_px[i], $urandom_range(0, 1));
         if (k == 2) begin
            long_hold = 300;
            for (int j = 0; j < 80; j++) send_pixel(rand_pixel(), 0);
         end
         for (int j = 0; j < 190; j++) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            if (j >= 60 && j < 100) gap = 0;
            send_pixel(rand_pixel(), gap);
         end
      end
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d pixels over %0d gain settings, %0d results checked", sent,
               gains.size() + 1, sb.checked);
      if (sb.errors == 0)
         $display("rgb_saturation_boost_pixel: match");
      else
         $display("rgb_saturation_boost_pixel: mismatch");
      $finish;
   end
endmodule

>>> sim.f
src/rsbp_pkg.sv
src/rsbp_div_pipe.sv
src/rsbp_sqrt_pipe.sv
src/rgb_saturation_boost_pixel.sv
bench/tb_rgb_saturation_boost_pixel.sv
